>>> src/assert_macros.svh
// Assertion macros for the filter block's RTL, used by its controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CWBM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define CWBM_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define CWBM_ASSERT(lbl, clk, rst, prop)
`define CWBM_ASSERT_NR(lbl, clk, prop)
`endif
`endif

>>> src/cwbm_pkg.sv
// Package with the types, codes and constants of the centre-weighted mean filter.
`default_nettype none
package cwbm_pkg;
  localparam int unsigned MAX_HALF_WIDTH_DEF  = 8;
  localparam int unsigned MAX_IMAGE_WIDTH_DEF = 1024;
  localparam int unsigned PIXEL_BITS_DEF      = 16;
  localparam int unsigned MAX_IMAGE_HEIGHT    = 4096;

  localparam int unsigned ROW_W      = 13;
  localparam int unsigned OROW_W     = 12;
  localparam int unsigned HW_REG_W   = 4;
  localparam int unsigned WQ_W       = 10;
  localparam int unsigned IW_W       = 11;
  localparam int unsigned IH_W       = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WIDTH,
    CFG_WEIGHT,
    CFG_IMG_WIDTH,
    CFG_IMG_HEIGHT
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SUM,
    S_FLUSH,
    S_MUL,
    S_ADD,
    S_DIVGO,
    S_DIV
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic sum_init;
    logic sum_step;
    logic mul;
    logic add;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic win_ready;
    logic sum_last;
    logic div_done;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

>>> src/cwbm_ifs.sv
// Handshake interfaces for the pixel, result and configuration channels.
`default_nettype none
interface cwbm_in_if #(parameter int unsigned PIXEL_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [PIXEL_BITS-1:0] pixel;
  modport source (output valid, output op, output pixel, input ready);
  modport sink (input valid, input op, input pixel, output ready);
endinterface

interface cwbm_out_if #(parameter int unsigned PIXEL_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] value;
  logic                  frame_end;
  modport source (output valid, output value, output frame_end, input ready);
  modport sink (input valid, input value, input frame_end, output ready);
endinterface

interface cwbm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/center_weighted_box_mean_2d.sv
// Top level of the centre-weighted box mean filter over a raster pixel stream.
//
//   channel     direction  payload
//   pixel_in    sink       op, pixel
//   result_out  source     value, frame_end
//   cfg         sink       index, data (always ready)
//
// A request that yields no result goes from S_IDLE through S_CHECK back to S_IDLE;
// one that yields a result also passes S_SUM, which reads the clipped window area
// (up to 289 entries) one entry a cycle from the single read port of the row store,
// then S_FLUSH, S_MUL, S_ADD, S_DIVGO and S_DIV, where the one-bit-per-cycle divider takes NUM_W (36 by default) steps.
// Reset is synchronous; the row store is not cleared, as no window reads an entry
// before it is written in the current frame.
// A stalled result stays in the output register while the next request is taken;
// a second result then waits in the divider until the output register is free.
`default_nettype none
module center_weighted_box_mean_2d import cwbm_pkg::*; #(
  parameter int unsigned MAX_HALF_WIDTH  = MAX_HALF_WIDTH_DEF,
  parameter int unsigned MAX_IMAGE_WIDTH = MAX_IMAGE_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS      = PIXEL_BITS_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  cwbm_in_if.sink     pixel_in,
  cwbm_out_if.source  result_out,
  cwbm_cfg_if.sink    cfg
);
  cmd_t cmd;
  sts_t sts;

  assign pixel_in.ready = cmd.take;
  assign cfg.ready      = 1'b1;

  cwbm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(pixel_in.valid),
    .sts     (sts),
    .cmd     (cmd)
  );

  cwbm_datapath #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH),
    .PIXEL_BITS     (PIXEL_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_valid     (pixel_in.valid),
    .in_op        (pixel_in.op),
    .in_pixel     (pixel_in.pixel),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_ready    (result_out.ready),
    .out_valid    (result_out.valid),
    .out_value    (result_out.value),
    .out_frame_end(result_out.frame_end)
  );
endmodule
`default_nettype wire

>>> src/cwbm_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module cwbm_div import cwbm_pkg::*; #(
  parameter int unsigned NUM_W = 36,
  parameter int unsigned DEN_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0]      quo,
  output logic                  done
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] qsh;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, qsh[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign quo   = qsh;

  // The done flag stays high from the end of a division until the next start.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qsh   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      qsh <= {qsh[NUM_W-2:0], ge};
    end
  end
endmodule
`default_nettype wire

>>> src/cwbm_datapath.sv
// Datapath: configuration, positions, row store, window sum, products and output register.
`default_nettype none
module cwbm_datapath import cwbm_pkg::*; #(
  parameter int unsigned MAX_HALF_WIDTH  = MAX_HALF_WIDTH_DEF,
  parameter int unsigned MAX_IMAGE_WIDTH = MAX_IMAGE_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS      = PIXEL_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic                  in_valid,
  input  wire logic                  in_op,
  input  wire logic [PIXEL_BITS-1:0] in_pixel,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [PIXEL_BITS-1:0]      out_value,
  output logic                       out_frame_end
);
  localparam int unsigned STORE_ROWS = 2 * MAX_HALF_WIDTH + 1;
  localparam int unsigned DEPTH      = STORE_ROWS * MAX_IMAGE_WIDTH;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned SLOT_W     = $clog2(STORE_ROWS);
  localparam int unsigned COL_W      = $clog2(MAX_IMAGE_WIDTH);
  localparam int unsigned EW_W       = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int unsigned HWE_W      = $clog2(MAX_HALF_WIDTH + 1);
  localparam int unsigned CS_W       = $clog2(MAX_IMAGE_WIDTH + MAX_HALF_WIDTH + 1);
  localparam int unsigned RS_W       = $clog2(MAX_IMAGE_HEIGHT + MAX_HALF_WIDTH + 1);
  localparam int unsigned SPAN_W     = $clog2(STORE_ROWS + 1);
  localparam int unsigned N_W        = $clog2(STORE_ROWS * STORE_ROWS + 1);
  localparam int unsigned S_W        = PIXEL_BITS + $clog2(STORE_ROWS * STORE_ROWS);
  localparam int unsigned NUM_W      = S_W + 11;
  localparam int unsigned DEN_W      = N_W + 11;

  logic [HW_REG_W-1:0] hw_reg;
  logic [WQ_W-1:0]     wq_reg;
  logic [IW_W-1:0]     iw_reg;
  logic [IH_W-1:0]     ih_reg;

  logic [HWE_W-1:0]  hw_eff;
  logic [EW_W-1:0]   w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [COL_W-1:0]  w_m1;
  logic [OROW_W-1:0] h_m1;

  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [SLOT_W-1:0] in_slot;
  logic [COL_W-1:0]  out_col;
  logic [OROW_W-1:0] out_row;
  logic [SLOT_W-1:0] out_slot;

  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr;
  logic                  wr;
  logic                  cfg_wr;

  logic [RS_W-1:0]    nr_raw;
  logic [CS_W-1:0]    nc_raw;
  logic [OROW_W-1:0]  nr;
  logic [COL_W-1:0]   nc;
  logic [OROW_W-1:0]  y0;
  logic [COL_W-1:0]   x0;
  logic [SPAN_W-1:0]  rows;
  logic [SPAN_W-1:0]  cols;
  logic [N_W-1:0]     n_val;
  logic [SLOT_W-1:0]  back;
  logic [SLOT_W-1:0]  y0_slot;
  logic [SLOT_W:0]    slot_sum;

  logic [OROW_W-1:0]     it_y;
  logic [COL_W-1:0]      it_x;
  logic [SLOT_W-1:0]     it_slot;
  logic [OROW_W-1:0]     wy1;
  logic [COL_W-1:0]      wx0;
  logic [COL_W-1:0]      wx1;
  logic [N_W-1:0]        n_reg;
  logic [PIXEL_BITS-1:0] rd_data;
  logic                  rd_valid;
  logic                  rd_center;
  logic [S_W-1:0]        acc;
  logic [PIXEL_BITS-1:0] cval;

  logic [PIXEL_BITS+N_W-1:0] p_c;
  logic [WQ_W+S_W-1:0]       p_w;
  logic [DEN_W-1:0]          den;
  logic [NUM_W-1:0]          num;
  logic [NUM_W-1:0]          quo;
  logic                      div_done;
  logic                      last;

  assign hw_eff = (32'(hw_reg) > MAX_HALF_WIDTH) ? HWE_W'(MAX_HALF_WIDTH) : HWE_W'(hw_reg);
  assign w_eff  = (iw_reg == '0) ? EW_W'(1) :
                  (32'(iw_reg) > MAX_IMAGE_WIDTH) ? EW_W'(MAX_IMAGE_WIDTH) : EW_W'(iw_reg);
  assign h_eff  = (ih_reg == '0) ? ROW_W'(1) :
                  (32'(ih_reg) > MAX_IMAGE_HEIGHT) ? ROW_W'(MAX_IMAGE_HEIGHT) : ROW_W'(ih_reg);
  assign w_m1   = COL_W'(w_eff - 1'b1);
  assign h_m1   = OROW_W'(h_eff - 1'b1);

  assign cfg_wr = cfg_valid;
  assign wr     = cmd.take && in_valid && (in_op == OP_PIXEL) && (in_row < h_eff);
  assign waddr  = ADDR_W'(32'(in_slot) * MAX_IMAGE_WIDTH + 32'(in_col));
  assign raddr  = ADDR_W'(32'(it_slot) * MAX_IMAGE_WIDTH + 32'(it_x));

  // Window bounds of the next output, clipped at the image borders.
  assign nr_raw = RS_W'(out_row) + RS_W'(hw_eff);
  assign nc_raw = CS_W'(out_col) + CS_W'(hw_eff);
  assign nr     = (nr_raw > RS_W'(h_m1)) ? h_m1 : OROW_W'(nr_raw);
  assign nc     = (nc_raw > CS_W'(w_m1)) ? w_m1 : COL_W'(nc_raw);
  assign y0     = (RS_W'(out_row) > RS_W'(hw_eff)) ?
                  OROW_W'(RS_W'(out_row) - RS_W'(hw_eff)) : '0;
  assign x0     = (CS_W'(out_col) > CS_W'(hw_eff)) ?
                  COL_W'(CS_W'(out_col) - CS_W'(hw_eff)) : '0;
  assign rows   = SPAN_W'(nr - y0) + 1'b1;
  assign cols   = SPAN_W'(nc - x0) + 1'b1;
  assign n_val  = N_W'(rows) * N_W'(cols) - 1'b1;
  assign back   = SLOT_W'(out_row - y0);
  assign slot_sum = (SLOT_W+1)'(out_slot) + (SLOT_W+1)'(STORE_ROWS) - (SLOT_W+1)'(back);
  assign y0_slot  = (out_slot >= back) ? (out_slot - back) : SLOT_W'(slot_sum);

  assign last = (out_row == h_m1) && (out_col == w_m1);

  assign sts.win_ready = (in_row > ROW_W'(nr)) || ((in_row == ROW_W'(nr)) && (in_col > nc));
  assign sts.sum_last  = (it_y == wy1) && (it_x == wx1);
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hw_reg <= HW_REG_W'(1);
      wq_reg <= WQ_W'(179);
      iw_reg <= IW_W'(1024);
      ih_reg <= IH_W'(1024);
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HALF_WIDTH: hw_reg <= cfg_data[HW_REG_W-1:0];
        CFG_WEIGHT:     wq_reg <= cfg_data[WQ_W-1:0];
        CFG_IMG_WIDTH:  iw_reg <= cfg_data[IW_W-1:0];
        CFG_IMG_HEIGHT: ih_reg <= cfg_data[IH_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
    end else begin
      if (wr) begin
        if (in_col == w_m1) begin
          in_col  <= '0;
          in_row  <= in_row + 1'b1;
          in_slot <= (in_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : in_slot + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (cmd.load_out) begin
        if (last) begin
          in_col   <= '0;
          in_row   <= '0;
          in_slot  <= '0;
          out_col  <= '0;
          out_row  <= '0;
          out_slot <= '0;
        end else if (out_col == w_m1) begin
          out_col  <= '0;
          out_row  <= out_row + 1'b1;
          out_slot <= (out_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : out_slot + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[waddr] <= in_pixel;
    end
    if (cmd.sum_step) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.sum_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_init) begin
      it_y    <= y0;
      it_x    <= x0;
      it_slot <= y0_slot;
      wy1     <= nr;
      wx0     <= x0;
      wx1     <= nc;
      n_reg   <= n_val;
    end else if (cmd.sum_step) begin
      rd_center <= (it_y == out_row) && (it_x == out_col);
      if (it_x == wx1) begin
        it_x    <= wx0;
        it_y    <= it_y + 1'b1;
        it_slot <= (it_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : it_slot + 1'b1;
      end else begin
        it_x <= it_x + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_init) begin
      acc <= '0;
    end else if (rd_valid) begin
      acc <= acc + S_W'(rd_data);
      if (rd_center) begin
        cval <= rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_c <= (PIXEL_BITS+N_W)'(cval) * (PIXEL_BITS+N_W)'(n_reg);
      p_w <= (WQ_W+S_W)'(wq_reg) * (WQ_W+S_W)'(acc - S_W'(cval));
      den <= DEN_W'(n_reg) * DEN_W'(11'd256 + 11'(wq_reg));
    end
    if (cmd.add) begin
      num <= NUM_W'({p_c, 8'b0}) + NUM_W'(p_w);
    end
  end

  cwbm_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (num),
    .den  (den),
    .quo  (quo),
    .done (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value     <= (n_reg == '0) ? cval : PIXEL_BITS'(quo);
      out_frame_end <= last;
    end
  end
endmodule
`default_nettype wire

>>> src/cwbm_ctrl.sv
// Controller state machine that sequences one request through the datapath.
`default_nettype none
`include "assert_macros.svh"
module cwbm_ctrl import cwbm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.win_ready) begin
          cmd.sum_init = 1'b1;
          state_next   = S_SUM;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.out_free) begin
            cmd.load_out = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `CWBM_ASSERT(a_accept_to_check, clk, rst, (state == S_IDLE && in_valid) |=> (state == S_CHECK))
  `CWBM_ASSERT(a_sum_holds, clk, rst, (state == S_SUM && !sts.sum_last) |=> (state == S_SUM))
  `CWBM_ASSERT(a_load_to_idle, clk, rst, cmd.load_out |=> (state == S_IDLE))
endmodule
`default_nettype wire

>>> test/center_weighted_box_mean_2d_checker.sv
// Checker that predicts the filter's results from the observed requests and compares them.
`timescale 1ns / 100ps
module center_weighted_box_mean_2d_checker import cwbm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        px_valid,
  input  wire logic        px_ready,
  input  wire logic        px_op,
  input  wire logic [15:0] px_pixel,
  input  wire logic        res_valid,
  input  wire logic        res_ready,
  input  wire logic [15:0] res_value,
  input  wire logic        res_frame_end,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire cfg_idx_t    cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               result_count,
  output int               frame_count
);
  localparam int ROWS = 2 * MAX_HALF_WIDTH_DEF + 1;

  logic [15:0] pixel_rows [ROWS][MAX_IMAGE_WIDTH_DEF];
  int unsigned hw_reg, wq_reg, iw_reg, ih_reg;
  int unsigned in_c, in_r, out_c, out_r;
  logic [16:0] expected_results [$];

  function automatic int unsigned clipped_hw();
    return hw_reg > MAX_HALF_WIDTH_DEF ? MAX_HALF_WIDTH_DEF : hw_reg;
  endfunction

  function automatic int unsigned clipped_w();
    if (iw_reg == 0) return 1;
    return iw_reg > MAX_IMAGE_WIDTH_DEF ? MAX_IMAGE_WIDTH_DEF : iw_reg;
  endfunction

  function automatic int unsigned clipped_h();
    if (ih_reg == 0) return 1;
    return ih_reg > MAX_IMAGE_HEIGHT ? MAX_IMAGE_HEIGHT : ih_reg;
  endfunction

  task automatic restart_frame();
    in_c = 0; in_r = 0; out_c = 0; out_r = 0;
  endtask

  task automatic predict_mean(input logic op, input logic [15:0] pix);
    int unsigned hw, w, h, nr, nc, y0, x0;
    longint unsigned total, centre, n, num, den, res;
    bit last;
    hw = clipped_hw(); w = clipped_w(); h = clipped_h();
    total = 0;
    if (op == OP_PIXEL && in_r < h) begin
      pixel_rows[in_r % ROWS][in_c] = pix;
      in_c++;
      if (in_c >= w) begin
        in_c = 0;
        in_r++;
      end
    end
    nr = out_r + hw; if (nr > h - 1) nr = h - 1;
    nc = out_c + hw; if (nc > w - 1) nc = w - 1;
    if (!(in_r > nr || (in_r == nr && in_c > nc))) return;
    y0 = out_r > hw ? out_r - hw : 0;
    x0 = out_c > hw ? out_c - hw : 0;
    for (int unsigned y = y0; y <= nr; y++)
      for (int unsigned x = x0; x <= nc; x++)
        total += pixel_rows[y % ROWS][x];
    centre = pixel_rows[out_r % ROWS][out_c];
    n = longint'(nr - y0 + 1) * longint'(nc - x0 + 1) - 1;
    if (n == 0) begin
      res = centre;
    end else begin
      num = centre * n * 256 + longint'(wq_reg) * (total - centre);
      den = n * (256 + wq_reg);
      res = num / den;
    end
    last = (out_r == h - 1 && out_c == w - 1);
    expected_results.push_back({last, res[15:0]});
    if (last) begin
      restart_frame();
    end else begin
      out_c++;
      if (out_c >= w) begin
        out_c = 0;
        out_r++;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got, input int unsigned exp);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [16:0] exp;
    if (rst) begin
      hw_reg = 1; wq_reg = 179; iw_reg = 1024; ih_reg = 1024;
      restart_frame();
      expected_results.delete();
      fail_count = 0;
      result_count <= 0; frame_count <= 0;
    end else begin
      if (res_valid && res_ready) begin
        result_count <= result_count + 1;
        if (res_frame_end) frame_count <= frame_count + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", res_value, 0);
        end else begin
          exp = expected_results.pop_front();
          if (res_value !== exp[15:0]) report_mismatch("value", res_value, exp[15:0]);
          if (res_frame_end !== exp[16]) report_mismatch("frame_end", res_frame_end, exp[16]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HALF_WIDTH: hw_reg = cfg_data[3:0];
          CFG_WEIGHT:     wq_reg = cfg_data[9:0];
          CFG_IMG_WIDTH:  iw_reg = cfg_data[10:0];
          CFG_IMG_HEIGHT: ih_reg = cfg_data[12:0];
        endcase
        restart_frame();
      end
      if (px_valid && px_ready) predict_mean(px_op, px_pixel);
    end
    pending <= expected_results.size();
  end
endmodule

>>> test/center_weighted_box_mean_2d_tb.sv
// Testbench top: drives pixel, drain and register requests into the filter and gives the verdict.
`timescale 1ns / 100ps
module center_weighted_box_mean_2d_tb import cwbm_pkg::*;;
  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle, recv_idle, fail_count, pending, result_count, frame_count;
  int   requests_sent;

  cwbm_in_if  pixel_in ();
  cwbm_out_if result_out ();
  cwbm_cfg_if cfg ();

  always #4 clk = ~clk;

  center_weighted_box_mean_2d u_top (
    .clk(clk), .rst(rst), .pixel_in(pixel_in.sink), .result_out(result_out.source), .cfg(cfg.sink)
  );

  center_weighted_box_mean_2d_checker u_checker (
    .clk(clk), .rst(rst),
    .px_valid(pixel_in.valid), .px_ready(pixel_in.ready), .px_op(pixel_in.op),
    .px_pixel(pixel_in.pixel),
    .res_valid(result_out.valid), .res_ready(result_out.ready), .res_value(result_out.value),
    .res_frame_end(result_out.frame_end),
    .cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_index(cfg_idx_t'(cfg.index)),
    .cfg_data(cfg.data),
    .fail_count(fail_count), .pending(pending), .result_count(result_count),
    .frame_count(frame_count)
  );

  initial begin
    pixel_in.valid = 1'b0; pixel_in.op = OP_PIXEL; pixel_in.pixel = '0;
    result_out.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
  end

  always @(posedge clk) begin
    if (rst) result_out.ready <= 1'b0;
    else result_out.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Valid stays high after an accepted request until the next one or an idle gap.
  task automatic send_request(input logic op, input logic [15:0] pix);
    if ($urandom_range(99) < send_idle) begin
      pixel_in.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    pixel_in.valid <= 1'b1;
    pixel_in.op    <= op;
    pixel_in.pixel <= pix;
    @(posedge clk iff pixel_in.ready);
    requests_sent++;
  endtask

  task automatic wait_until_quiet();
    pixel_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input int unsigned val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val[15:0];
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filter(input int unsigned hw, wq, iw, ih);
    wait_until_quiet();
    write_register(CFG_HALF_WIDTH, hw);
    write_register(CFG_WEIGHT, wq);
    write_register(CFG_IMG_WIDTH, iw);
    write_register(CFG_IMG_HEIGHT, ih);
  endtask

  // A whole frame of pixels (FFFF, random FFFF/0000 or random), then drains for trailing outputs.
  task automatic send_frame(input int unsigned npix, input int unsigned ndrain);
    int unsigned mode;
    mode = $urandom_range(3);
    for (int unsigned i = 0; i < npix; i++) begin
      case (mode)
        0: send_request(OP_PIXEL, 16'hFFFF);
        1: send_request(OP_PIXEL, $urandom_range(1) ? 16'hFFFF : 16'h0000);
        default: send_request(OP_PIXEL, 16'($urandom_range(65535)));
      endcase
    end
    for (int unsigned i = 0; i < ndrain; i++) send_request(OP_DRAIN, 16'($urandom_range(65535)));
  endtask

  task automatic random_phase(input int unsigned budget);
    int unsigned hw, iw, ih, wq, r, ndrain, cost;
    while (budget > 0) begin
      r  = $urandom_range(9);
      hw = (r == 0) ? 8 : (r == 1) ? 1 : $urandom_range(1, 4);
      iw = (r == 2) ? 1 : $urandom_range(1, 12);
      ih = (r == 3) ? 1 : $urandom_range(1, 10);
      wq = (r == 4) ? 3 : (r == 5) ? 512 : $urandom_range(3, 512);
      set_filter(hw, wq, iw, ih);
      ndrain = $urandom_range(1, 3) * (iw * (hw + 1) + 2);
      send_frame(iw * ih, ndrain);
      cost = iw * ih + ndrain;
      // Occasionally extra pixel or drain requests after the frame; the pixels start the next image.
      if ($urandom_range(4) == 0) begin
        for (int i = 0; i < 5; i++)
          send_request(1'($urandom_range(1)), 16'($urandom_range(65535)));
        cost = cost + 5;
      end
      budget = (budget > cost) ? budget - cost : 0;
    end
  endtask

  initial begin
    requests_sent = 0;
    send_idle = 31; recv_idle = 55;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: a single pixel image, extreme values and a wide window over a tiny frame.
    set_filter(1, 3, 1, 1);
    send_request(OP_PIXEL, 16'hFFFF);
    send_request(OP_DRAIN, 16'h0000);
    set_filter(8, 512, 3, 2);
    send_request(OP_PIXEL, 16'h0000);
    send_request(OP_PIXEL, 16'hFFFF);
    send_request(OP_PIXEL, 16'h5555);
    send_request(OP_PIXEL, 16'hAAAA);
    send_request(OP_PIXEL, 16'hFFFF);
    send_request(OP_PIXEL, 16'h0001);
    send_request(OP_DRAIN, 16'h0000);
    send_request(OP_PIXEL, 16'h1234);
    set_filter(15, 1023, 0, 0);
    send_request(OP_PIXEL, 16'h8000);
    set_filter(1, 179, 2047, 8191);
    send_request(OP_PIXEL, 16'h7FFF);
    send_request(OP_DRAIN, 16'h0000);
    set_filter(2, 256, 4, 3);
    send_frame(12, 15);
    random_phase(650);
    send_idle = 55; recv_idle = 31;
    random_phase(650);
    send_idle = 0; recv_idle = 0;
    random_phase(650);
    wait_until_quiet();
    $display("Sent %0d requests; %0d results checked across %0d completed frames.",
             requests_sent, result_count, frame_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
